// ===== hw/rtl/aht_pkg.sv =====
`timescale 1ns / 1ps

package aht_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int COORD_WIDTH   = 32;

  localparam int IDX_W   = 11;
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int HA_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int SHIFT_W = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // a00 bits 1:0, a01 bits 3:2, a10 bits 5:4, a11 bits 7:6
  localparam logic [7:0] IDENTITY_LIN = 8'h41;

  typedef enum logic [2:0] {
    OP_ROT_CW   = 3'd0,
    OP_ROT_CCW  = 3'd1,
    OP_MIRROR_X = 3'd2,
    OP_MIRROR_Y = 3'd3,
    OP_QUERY    = 3'd4
  } op_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [HA_W-1:0]     addr;
    logic [7:0]          lin;
    logic [SHIFT_W-1:0]  data_x;
    logic [SHIFT_W-1:0]  data_y;
    logic                index_error;
    logic                identity;
  } cmd_t;

  typedef struct packed {
    logic [7:0]          lin;
    logic [SHIFT_W-1:0]  sx;
    logic [SHIFT_W-1:0]  sy;
  } hist_t;

  function automatic logic [SHIFT_W-1:0] coord_ext(input logic [31:0] v);
    return SHIFT_W'(signed'(v[COORD_WIDTH-1:0]));
  endfunction

  // coefficient in {-1,0,1} times a wrapped value
  function automatic logic [SHIFT_W-1:0] scale(input logic [1:0] c,
                                               input logic [SHIFT_W-1:0] v);
    logic [SHIFT_W-1:0] r;
    case (c)
      2'b01:   r = v;
      2'b11:   r = SHIFT_W'(0) - v;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/affine_history_point_transform_core.sv =====
`timescale 1ns / 1ps

// Running 2D affine transform with a history of every composed transform.
// A request is taken at a rising edge where start is high and busy is low;
// one request can be taken every cycle. Ops 0 to 3 (rotate clockwise,
// rotate counter-clockwise, mirror x about axis_pos, mirror y about
// axis_pos) update the running transform in the front end in the cycle
// they are taken, append it to the history and give no result; once the
// history holds HISTORY_DEPTH entries they are dropped. Op 4 maps
// (point_x_i, point_y_i) by history entry history_index_i (entry 0 is the
// identity) and gives one result, on the result ports for exactly one
// cycle under result_strobe_o: the request enters the command queue at the
// edge that takes it, the back end pops it and registers the history
// memory read, and then registers the multiply-free 64-bit sum together
// with result_strobe_o. An entry above the number written so far returns
// zeros with index_error_o set. Op codes 5 to 7 are dropped. Results
// follow request order and the receiver cannot hold them off. busy is high
// only while the four-entry command queue is full; the back end drains one
// command every cycle, so at most one is ever held and busy stays low.
// Translations wrap at 64 bits.
module affine_history_point_transform_core import aht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op_i,
  input  logic [31:0]        axis_pos_i,
  input  logic [IDX_W-1:0]   history_index_i,
  input  logic [31:0]        point_x_i,
  input  logic [31:0]        point_y_i,
  output logic               result_strobe_o,
  output logic [SHIFT_W-1:0] result_x_o,
  output logic [SHIFT_W-1:0] result_y_o,
  output logic               index_error_o
);

  logic accept;
  logic push, pop, full, empty;
  cmd_t cmd_in, cmd_out;

  // take a request only while the queue has room
  assign busy   = full;
  assign accept = start && !busy;

  // front end: classify, advance the running transform, build commands
  aht_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .op_i            (op_i),
    .axis_pos_i      (axis_pos_i),
    .history_index_i (history_index_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  // hold commands in order between the two halves
  aht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  // back end: write or read the history memory, map the point
  aht_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .strobe_o      (result_strobe_o),
    .result_x_o    (result_x_o),
    .result_y_o    (result_y_o),
    .index_error_o (index_error_o)
  );

endmodule

// ===== hw/rtl/aht_queue.sv =====
`timescale 1ns / 1ps

module aht_queue import aht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aht_front.sv =====
`timescale 1ns / 1ps

module aht_front import aht_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        op_i,
  input  logic [31:0]       axis_pos_i,
  input  logic [IDX_W-1:0]  history_index_i,
  input  logic [31:0]       point_x_i,
  input  logic [31:0]       point_y_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic [7:0]         lin_q, lin_d;
  logic [SHIFT_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         e0, e1, e2, e3;
  logic [1:0]         n0, n1, n2, n3;
  logic [SHIFT_W-1:0] axis_ext;
  logic [SHIFT_W-1:0] twop;
  logic               hist_full;
  logic               upd;

  assign e0 = lin_q[1:0];
  assign e1 = lin_q[3:2];
  assign e2 = lin_q[5:4];
  assign e3 = lin_q[7:6];
  assign axis_ext  = coord_ext(axis_pos_i);
  assign twop      = {axis_ext[SHIFT_W-2:0], 1'b0};
  assign hist_full = (cnt_q == CNT_W'(HISTORY_DEPTH));

  always_comb begin
    n0 = e0; n1 = e1; n2 = e2; n3 = e3;
    sx_d = sx_q;
    sy_d = sy_q;
    upd  = 1'b0;
    push_o = 1'b0;
    cmd_o  = '0;
    cmd_o.kind = CMD_WRITE;
    case (op_e'(op_i))
      OP_ROT_CW: begin
        upd = 1'b1;
        n0 = e2; n1 = e3; n2 = 2'b00 - e0; n3 = 2'b00 - e1;
        sx_d = sy_q;
        sy_d = SHIFT_W'(0) - sx_q;
      end
      OP_ROT_CCW: begin
        upd = 1'b1;
        n0 = 2'b00 - e2; n1 = 2'b00 - e3; n2 = e0; n3 = e1;
        sx_d = SHIFT_W'(0) - sy_q;
        sy_d = sx_q;
      end
      OP_MIRROR_X: begin
        upd = 1'b1;
        n0 = 2'b00 - e0; n1 = 2'b00 - e1;
        sx_d = twop - sx_q;
      end
      OP_MIRROR_Y: begin
        upd = 1'b1;
        n2 = 2'b00 - e2; n3 = 2'b00 - e3;
        sy_d = twop - sy_q;
      end
      OP_QUERY: begin
        push_o = accept_i;
        cmd_o.kind        = CMD_QUERY;
        cmd_o.index_error = (CMP_W'(history_index_i) > CMP_W'(cnt_q));
        cmd_o.identity    = (history_index_i == '0);
        cmd_o.addr        = HA_W'(history_index_i - 1'b1);
        cmd_o.data_x      = coord_ext(point_x_i);
        cmd_o.data_y      = coord_ext(point_y_i);
      end
      default: upd = 1'b0;
    endcase
    lin_d = {n3, n2, n1, n0};
    cnt_d = cnt_q;
    if (upd && !hist_full && accept_i) begin
      push_o       = 1'b1;
      cmd_o.addr   = HA_W'(cnt_q);
      cmd_o.lin    = lin_d;
      cmd_o.data_x = sx_d;
      cmd_o.data_y = sy_d;
      cnt_d        = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= IDENTITY_LIN;
      sx_q  <= '0;
      sy_q  <= '0;
      cnt_q <= '0;
    end else if (upd && !hist_full && accept_i) begin
      lin_q <= lin_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/aht_back.sv =====
`timescale 1ns / 1ps

module aht_back import aht_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  cmd_t               cmd_i,
  output logic               pop_o,
  output logic               strobe_o,
  output logic [SHIFT_W-1:0] result_x_o,
  output logic [SHIFT_W-1:0] result_y_o,
  output logic               index_error_o
);

  hist_t              hist_mem_q [HISTORY_DEPTH];
  hist_t              rd_q;
  logic               qv_q;
  logic               err_q, ident_q;
  logic [SHIFT_W-1:0] px_q, py_q;
  logic [7:0]         lin;
  logic [SHIFT_W-1:0] tx, ty;
  logic               strobe_q, err_out_q;
  logic [SHIFT_W-1:0] rx_q, ry_q;

  assign pop_o = !empty_i;

  // memory: one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.kind == CMD_WRITE) begin
      hist_mem_q[cmd_i.addr] <= '{lin: cmd_i.lin, sx: cmd_i.data_x, sy: cmd_i.data_y};
    end
    if (pop_o && cmd_i.kind == CMD_QUERY) begin
      rd_q <= hist_mem_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      err_q   <= cmd_i.index_error;
      ident_q <= cmd_i.identity;
      px_q    <= cmd_i.data_x;
      py_q    <= cmd_i.data_y;
    end
  end

  always_comb begin
    lin = ident_q ? IDENTITY_LIN : rd_q.lin;
    tx  = ident_q ? '0 : rd_q.sx;
    ty  = ident_q ? '0 : rd_q.sy;
  end

  always_ff @(posedge clk_i) begin
    if (qv_q) begin
      err_out_q <= err_q;
      rx_q <= err_q ? '0 : scale(lin[1:0], px_q) + scale(lin[3:2], py_q) + tx;
      ry_q <= err_q ? '0 : scale(lin[5:4], px_q) + scale(lin[7:6], py_q) + ty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q     <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      qv_q     <= pop_o && cmd_i.kind == CMD_QUERY;
      strobe_q <= qv_q;
    end
  end

  assign strobe_o      = strobe_q;
  assign result_x_o    = rx_q;
  assign result_y_o    = ry_q;
  assign index_error_o = err_out_q;

endmodule

// ===== hw/rtl/aht_checker.sv =====
`timescale 1ns / 1ps

module aht_checker import aht_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [2:0]         op_i,
  input logic [IDX_W-1:0]   history_index_i,
  input logic [31:0]        point_x_i,
  input logic [31:0]        point_y_i,
  input logic               result_strobe_o,
  input logic [SHIFT_W-1:0] result_x_o,
  input logic [SHIFT_W-1:0] result_y_o,
  input logic               index_error_o
);

  logic query_taken;
  assign query_taken = start && !busy && (op_i == OP_QUERY);

  a_query_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_taken |-> ##3 result_strobe_o)
    else $error("query request not answered");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(query_taken, 3))
    else $error("result without a query request");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && index_error_o) |-> (result_x_o == '0 && result_y_o == '0))
    else $error("index error with non-zero result");

  a_identity_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_taken && history_index_i == '0) |-> ##3
      (!index_error_o && result_x_o == coord_ext($past(point_x_i, 3))
       && result_y_o == coord_ext($past(point_y_i, 3))))
    else $error("entry zero does not map to identity");

endmodule

bind affine_history_point_transform_core aht_checker u_aht_checker (.*);
